### rtl/tsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tsd_pkg;
  typedef enum logic [1:0] {
    CMD_OFF   = 2'd0,
    CMD_LEFT  = 2'd1,
    CMD_RIGHT = 2'd2
  } cmd_t;

  localparam int unsigned WIN_W   = 40;
  localparam int unsigned STAMP_W = 63;
  localparam int unsigned SCORE_W = 32;

  localparam logic [0:0] REG_RELEASE  = 1'b0;
  localparam logic [0:0] REG_ACTIVATE = 1'b1;

  localparam logic [WIN_W-1:0] RELEASE_RESET  = 40'd1000000000;
  localparam logic [WIN_W-1:0] ACTIVATE_RESET = 40'd300000000;

  // exponent all ones means nan or infinity
  function automatic logic score_finite(input logic [SCORE_W-1:0] bits);
    score_finite = (bits[30:23] != 8'hFF);
  endfunction

  // monotonic ordering key, both zeros map to the same key
  function automatic logic [SCORE_W:0] score_key(input logic [SCORE_W-1:0] bits);
    logic [SCORE_W:0] mag;
    mag = {2'b00, bits[30:0]};
    if (bits[31] && (mag != '0)) begin
      score_key = {1'b0, 32'h8000_0000} - mag;
    end else begin
      score_key = {1'b0, 32'h8000_0000} + mag;
    end
  endfunction
endpackage
`default_nettype wire

### rtl/turn_signal_debounce_top.sv
`timescale 1ns / 1ps
`default_nettype none
// the result of each input transaction is registered in the output register
// one observation per cycle while out_ready keeps the output taken, set by the single registered state update
// the output register refills in the cycle it is taken, so there is no bubble
// reset (synchronous, rst high): command off, all pending evidence cleared,
// windows back to 1000000000 ns release and 300000000 ns activate
module turn_signal_debounce_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        shape_valid,
  input  wire logic [31:0] score_off,
  input  wire logic [31:0] score_left,
  input  wire logic [31:0] score_right,
  input  wire logic [62:0] time_stamp,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       command
);
  localparam int unsigned WW = tsd_pkg::WIN_W;
  localparam int unsigned SW = tsd_pkg::STAMP_W;

  logic [WW-1:0] release_window;
  logic [WW-1:0] activate_window;

  logic [1:0]    stable;
  logic [1:0]    stable_next;
  logic          cand_valid, cand_valid_next;
  logic [1:0]    cand_cmd, cand_cmd_next;
  logic [SW-1:0] cand_start, cand_start_next;
  logic          contra_valid, contra_valid_next;
  logic [SW-1:0] contra_start, contra_start_next;
  logic          prev_valid, prev_valid_next;
  logic [SW-1:0] prev_stamp, prev_stamp_next;

  logic accept;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      release_window  <= tsd_pkg::RELEASE_RESET;
      activate_window <= tsd_pkg::ACTIVATE_RESET;
    end else if (cfg_write && paddr[3] == tsd_pkg::REG_RELEASE && paddr[2:0] == 3'd0) begin
      release_window <= pwdata[WW-1:0];
    end else if (cfg_write && paddr[3] == tsd_pkg::REG_ACTIVATE && paddr[2:0] == 3'd0) begin
      activate_window <= pwdata[WW-1:0];
    end
  end

  // register read back
  always_comb begin
    prdata = '0;
    case (paddr[3])
      tsd_pkg::REG_RELEASE:  prdata = {{(64-WW){1'b0}}, release_window};
      tsd_pkg::REG_ACTIVATE: prdata = {{(64-WW){1'b0}}, activate_window};
      default:               prdata = '0;
    endcase
  end

  // observation decode
  logic            finite_all;
  logic [32:0]     k_off, k_left, k_right, best01;
  logic [1:0]      observed;
  logic [1:0]      obs01;
  always_comb begin
    finite_all = shape_valid && tsd_pkg::score_finite(score_off)
                 && tsd_pkg::score_finite(score_left) && tsd_pkg::score_finite(score_right);
    k_off   = tsd_pkg::score_key(score_off);
    k_left  = tsd_pkg::score_key(score_left);
    k_right = tsd_pkg::score_key(score_right);
    if (k_off < k_left) begin
      best01 = k_left;
      obs01  = tsd_pkg::CMD_LEFT;
    end else begin
      best01 = k_off;
      obs01  = tsd_pkg::CMD_OFF;
    end
    observed = (best01 < k_right) ? 2'(tsd_pkg::CMD_RIGHT) : obs01;
  end

  // debounce state update
  logic          backwards, cv, ctv, active, cand_held, contra_held;
  logic [SW-1:0] cs, cts;
  logic [WW-1:0] window;
  logic [SW-1:0] cand_elapsed, contra_elapsed;
  always_comb begin
    stable_next       = stable;
    cand_valid_next   = cand_valid;
    cand_cmd_next     = cand_cmd;
    cand_start_next   = cand_start;
    contra_valid_next = contra_valid;
    contra_start_next = contra_start;
    prev_valid_next   = prev_valid;
    prev_stamp_next   = prev_stamp;
    backwards   = prev_valid && (time_stamp < prev_stamp);
    cv          = cand_valid && !backwards;
    ctv         = contra_valid && !backwards;
    cs          = (!cv || cand_cmd != observed) ? time_stamp : cand_start;
    cts         = ctv ? contra_start : time_stamp;
    active      = (stable != tsd_pkg::CMD_OFF);
    window      = active ? release_window : activate_window;
    cand_elapsed   = time_stamp - cs;
    contra_elapsed = time_stamp - cts;
    cand_held   = (time_stamp >= cs) && (cand_elapsed >= {{(SW-WW){1'b0}}, window});
    contra_held = (time_stamp >= cts) && (contra_elapsed >= {{(SW-WW){1'b0}}, window});
    if (!finite_all) begin
      stable_next       = tsd_pkg::CMD_OFF;
      cand_valid_next   = 1'b0;
      contra_valid_next = 1'b0;
      prev_valid_next   = 1'b0;
    end else begin
      prev_valid_next = 1'b1;
      prev_stamp_next = time_stamp;
      if (observed == stable) begin
        cand_valid_next   = 1'b0;
        contra_valid_next = 1'b0;
      end else begin
        cand_valid_next   = 1'b1;
        cand_cmd_next     = observed;
        cand_start_next   = cs;
        contra_valid_next = 1'b1;
        contra_start_next = cts;
        if (cand_held) begin
          stable_next       = observed;
          cand_valid_next   = 1'b0;
          contra_valid_next = 1'b0;
        end else if (active && contra_held) begin
          stable_next       = tsd_pkg::CMD_OFF;
          cand_valid_next   = 1'b0;
          contra_valid_next = 1'b0;
        end
      end
    end
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stable       <= tsd_pkg::CMD_OFF;
      cand_valid   <= 1'b0;
      cand_cmd     <= '0;
      cand_start   <= '0;
      contra_valid <= 1'b0;
      contra_start <= '0;
      prev_valid   <= 1'b0;
      prev_stamp   <= '0;
      out_valid    <= 1'b0;
      command      <= tsd_pkg::CMD_OFF;
    end else begin
      if (accept) begin
        stable       <= stable_next;
        cand_valid   <= cand_valid_next;
        cand_cmd     <= cand_cmd_next;
        cand_start   <= cand_start_next;
        contra_valid <= contra_valid_next;
        contra_start <= contra_start_next;
        prev_valid   <= prev_valid_next;
        prev_stamp   <= prev_stamp_next;
        command      <= stable_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result always matches the stable command it reports
  a_cmd_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (command == stable)) else $error("command differs from state");
  // an invalid observation forces off
  a_force_off: assert property (@(posedge clk) disable iff (rst)
    (accept && !shape_valid) |=> (command == tsd_pkg::CMD_OFF && !cand_valid && !contra_valid))
    else $error("invalid shape did not force off");
  // a pending candidate never names the stable command
  a_cand_differs: assert property (@(posedge clk) disable iff (rst)
    cand_valid |-> (cand_cmd != stable)) else $error("candidate equals stable command");
  // command code stays in range
  a_cmd_range: assert property (@(posedge clk) disable iff (rst)
    stable != 2'd3) else $error("stable command out of range");
endmodule
`default_nettype wire
